// ===== rtl/vfbb_pkg.sv =====
`timescale 1ns / 1ps
// shared constants and types for the volume foreground bounding box
// no dependencies

package vfbb_pkg;

	localparam int SAMPLE_BITS_DEF = 16;
	localparam int COORD_BITS_DEF  = 16;

	// configuration register indexes
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_X_FIRST = 3'd0,
		REG_X_LAST  = 3'd1,
		REG_Y_FIRST = 3'd2,
		REG_Y_LAST  = 3'd3,
		REG_Z_FIRST = 3'd4,
		REG_Z_LAST  = 3'd5
	} cfg_reg_t;

	// reset value of the last-index registers when COORD_BITS is 9 or more
	localparam int LAST_RESET = 255;

endpackage

// ===== rtl/vfbb_if.sv =====
`timescale 1ns / 1ps
// channel interfaces: voxel stream, bounding box results, register writes
// uses vfbb_pkg for the register index width and the default widths

interface vfbb_voxel_if #(
	parameter int SAMPLE_BITS = vfbb_pkg::SAMPLE_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] voxel_value;

	modport source (output valid, output voxel_value, input ready);
	modport sink   (input valid, input voxel_value, output ready);
endinterface

interface vfbb_bbox_if #(
	parameter int COORD_BITS = vfbb_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] lowest_x;
	logic signed [COORD_BITS-1:0] highest_x;
	logic signed [COORD_BITS-1:0] lowest_y;
	logic signed [COORD_BITS-1:0] highest_y;
	logic signed [COORD_BITS-1:0] lowest_z;
	logic signed [COORD_BITS-1:0] highest_z;
	logic                         found_any;

	modport source (
		output valid, output lowest_x, output highest_x, output lowest_y,
		output highest_y, output lowest_z, output highest_z, output found_any,
		input ready
	);
	modport sink (
		input valid, input lowest_x, input highest_x, input lowest_y,
		input highest_y, input lowest_z, input highest_z, input found_any,
		output ready
	);
endinterface

interface vfbb_cfg_if #(
	parameter int COORD_BITS = vfbb_pkg::COORD_BITS_DEF
);
	logic                                    valid;
	logic                                    ready;
	logic [vfbb_pkg::CFG_INDEX_BITS-1:0]     index;
	logic [COORD_BITS-1:0]                   data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/volume_foreground_bounding_box.sv =====
`timescale 1ns / 1ps
// foreground bounding box of a raster-ordered 3D volume
// depends on vfbb_pkg and the interfaces in vfbb_if.sv
//
//  port   | role   | moves
//  -------+--------+-------------------------------------------
//  voxel  | sink   | one voxel sample per transfer, raster order
//  bbox   | source | six bounds and found flag, one per volume
//  cfg    | sink   | extent register write (index, data)
//
// one voxel per cycle while no result is held; a voxel's compares and counter
// updates run in the input register, and the result of a volume is loaded into
// the output register when the last voxel of the volume leaves the input register.
// arst_n resets all control state and loads the default extent.
// a stalled result holds the voxel in the input register; no voxel is lost.
// cfg is always ready.

module volume_foreground_bounding_box #(
	parameter int SAMPLE_BITS = vfbb_pkg::SAMPLE_BITS_DEF,
	parameter int COORD_BITS  = vfbb_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	vfbb_voxel_if.sink  voxel,
	vfbb_bbox_if.source bbox,
	vfbb_cfg_if.sink    cfg
);
	import vfbb_pkg::*;

	localparam int LAST_RST_I = (COORD_BITS >= 9) ? LAST_RESET : (2 ** (COORD_BITS - 1)) - 1;
	localparam logic signed [COORD_BITS-1:0] LAST_RST = COORD_BITS'(LAST_RST_I);
	localparam logic signed [COORD_BITS-1:0] ONE = COORD_BITS'(1);

	typedef logic signed [COORD_BITS-1:0] coord_t;

	// extent registers
	coord_t x_first_q, x_last_q, y_first_q, y_last_q, z_first_q, z_last_q;

	// volume state
	logic [SAMPLE_BITS-1:0] background_q;
	logic                   first_pending_q;
	coord_t                 col_q, row_q, slice_q;
	logic                   row_hit_q, slice_hit_q, any_hit_q;
	coord_t                 min_col_q, max_col_q, min_row_q, max_row_q;
	coord_t                 min_slice_q, max_slice_q;

	// input register
	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;

	// result register
	logic   out_valid_q;
	coord_t lowest_x_q, highest_x_q, lowest_y_q, highest_y_q, lowest_z_q, highest_z_q;
	logic   found_any_q;

	logic advance, s1_fire, in_fire;

	assign advance = !out_valid_q || bbox.ready;
	assign s1_fire = valid_s1 && advance;
	assign voxel.ready = !valid_s1 || advance;
	assign in_fire = voxel.valid && voxel.ready;
	assign cfg.ready = 1'b1;

	// effective state with the volume-start load folded in
	logic   fp, hit, rh, sh, ah, rh_n, sh_n, ah_n;
	coord_t c, r, s, mnc, mxc, mnr, mxr, mns, mxs;
	coord_t mnc_n, mxc_n, mnr_n, mxr_n, mns_n, mxs_n;
	coord_t col_n, row_n, slice_n;
	logic   end_row, end_slice, end_vol;
	logic   row_hit_n, slice_hit_n;

	always_comb begin
		fp  = first_pending_q;
		c   = fp ? x_first_q : col_q;
		r   = fp ? y_first_q : row_q;
		s   = fp ? z_first_q : slice_q;
		rh  = fp ? 1'b0 : row_hit_q;
		sh  = fp ? 1'b0 : slice_hit_q;
		ah  = fp ? 1'b0 : any_hit_q;
		mnc = fp ? x_last_q : min_col_q;
		mxc = fp ? x_first_q : max_col_q;
		mnr = fp ? y_last_q : min_row_q;
		mxr = fp ? y_first_q : max_row_q;
		mns = fp ? z_last_q : min_slice_q;
		mxs = fp ? z_first_q : max_slice_q;

		hit  = !fp && (sample_s1 != background_q);
		rh_n = rh || hit;
		sh_n = sh || hit;
		ah_n = ah || hit;
		mnc_n = (hit && c < mnc) ? c : mnc;
		mxc_n = (hit && c > mxc) ? c : mxc;

		end_row   = c >= x_last_q;
		end_slice = end_row && (r >= y_last_q);
		end_vol   = end_slice && (s >= z_last_q);

		mnr_n = (end_row && rh_n && r < mnr) ? r : mnr;
		mxr_n = (end_row && rh_n && r > mxr) ? r : mxr;
		mns_n = (end_slice && sh_n && s < mns) ? s : mns;
		mxs_n = (end_slice && sh_n && s > mxs) ? s : mxs;

		row_hit_n   = end_row ? 1'b0 : rh_n;
		slice_hit_n = end_slice ? 1'b0 : sh_n;

		col_n   = end_row ? x_first_q : c + ONE;
		row_n   = r;
		slice_n = s;
		if (end_row) begin
			if (!end_slice) begin
				row_n = r + ONE;
			end else begin
				row_n   = y_first_q;
				slice_n = end_vol ? z_first_q : s + ONE;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_first_q <= '0;
			x_last_q  <= LAST_RST;
			y_first_q <= '0;
			y_last_q  <= LAST_RST;
			z_first_q <= '0;
			z_last_q  <= LAST_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_X_FIRST: x_first_q <= cfg.data;
				REG_X_LAST:  x_last_q  <= cfg.data;
				REG_Y_FIRST: y_first_q <= cfg.data;
				REG_Y_LAST:  y_last_q  <= cfg.data;
				REG_Z_FIRST: z_first_q <= cfg.data;
				REG_Z_LAST:  z_last_q  <= cfg.data;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (voxel.ready) begin
			valid_s1 <= voxel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= voxel.voxel_value;
		end
	end

	// volume state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			background_q    <= '0;
			first_pending_q <= 1'b1;
			col_q           <= '0;
			row_q           <= '0;
			slice_q         <= '0;
			row_hit_q       <= 1'b0;
			slice_hit_q     <= 1'b0;
			any_hit_q       <= 1'b0;
			min_col_q       <= LAST_RST;
			max_col_q       <= '0;
			min_row_q       <= LAST_RST;
			max_row_q       <= '0;
			min_slice_q     <= LAST_RST;
			max_slice_q     <= '0;
		end else if (s1_fire) begin
			if (fp) begin
				background_q <= sample_s1;
			end
			first_pending_q <= end_vol;
			col_q           <= col_n;
			row_q           <= row_n;
			slice_q         <= slice_n;
			row_hit_q       <= row_hit_n;
			slice_hit_q     <= slice_hit_n;
			any_hit_q       <= ah_n;
			min_col_q       <= mnc_n;
			max_col_q       <= mxc_n;
			min_row_q       <= mnr_n;
			max_row_q       <= mxr_n;
			min_slice_q     <= mns_n;
			max_slice_q     <= mxs_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= s1_fire && end_vol;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && end_vol) begin
			lowest_x_q  <= mnc_n;
			highest_x_q <= mxc_n;
			lowest_y_q  <= mnr_n;
			highest_y_q <= mxr_n;
			lowest_z_q  <= mns_n;
			highest_z_q <= mxs_n;
			found_any_q <= ah_n;
		end
	end

	assign bbox.valid     = out_valid_q;
	assign bbox.lowest_x  = lowest_x_q;
	assign bbox.highest_x = highest_x_q;
	assign bbox.lowest_y  = lowest_y_q;
	assign bbox.highest_y = highest_y_q;
	assign bbox.lowest_z  = lowest_z_q;
	assign bbox.highest_z = highest_z_q;
	assign bbox.found_any = found_any_q;

	// a finished volume rearms the background latch
	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_fire && end_vol) |=> first_pending_q)
		else $error("volume end did not rearm");

	// the input side only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!voxel.ready |-> (bbox.valid && !bbox.ready))
		else $error("input stalled without a held result");

	// a found box is never inverted
	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		(bbox.valid && bbox.found_any) |->
			(lowest_x_q <= highest_x_q && lowest_y_q <= highest_y_q
			&& lowest_z_q <= highest_z_q))
		else $error("found box has inverted bounds");

endmodule
